/* sv/escu_pkg.sv */
// ----------------------------------------------------------------------------
// escu_pkg : shared types and constants
// beat layouts, calibration bank and inter-stage records of the compensation
// pipeline
// ----------------------------------------------------------------------------
package escu_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int DIV_W = 64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_CALIB    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_CALIB_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_CALIB_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_CALIB_C = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_CALIB     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_CALIB_H6  = 3'd5;

  // formula constants
  localparam logic [32:0] TEMP_PRESS_OFS = 33'd128000;
  localparam logic [31:0] TEMP_HUM_OFS   = 32'd76800;
  localparam logic [63:0] PRESS_FULL     = 64'd1048576;
  localparam logic [63:0] PRESS_SCALE    = 64'd3125;
  localparam logic [63:0] PRESS_BIAS     = 64'h0000_8000_0000_0000;
  localparam logic [31:0] HUM_ROUND      = 32'd16384;
  localparam logic [31:0] HUM_HALF       = 32'd32768;
  localparam logic [31:0] HUM_OFS        = 32'd2097152;
  localparam logic [31:0] HUM_ROUND_B    = 32'd8192;
  localparam logic [31:0] HUM_MAX        = 32'd419430400;
  localparam logic [31:0] TEMP_ROUND     = 32'd128;
  localparam logic [16:0] HUM_OUT_MAX    = 17'd102400;

  typedef struct packed {
    logic [19:0] adc_temp;
    logic [19:0] adc_press;
    logic [15:0] adc_hum;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] temp_centi_deg;
    logic [31:0]        press_q24_8;
    logic [16:0]        hum_q22_10;
  } out_beat_t;

  typedef struct packed {
    logic [47:0] temp;
    logic [63:0] press_a;
    logic [63:0] press_b;
    logic [15:0] press_c;
    logic [63:0] hum;
    logic [7:0]  hum_h6;
  } calib_t;

  typedef struct packed {
    logic [31:0] tc;
    logic [32:0] v1;
    logic [31:0] x;
    logic [19:0] adc_press;
    logic [15:0] adc_hum;
  } temp_res_t;

  typedef struct packed {
    logic [31:0] tc;
    logic [16:0] hum;
  } side_t;

  typedef struct packed {
    logic [DIV_W-1:0] ua;
    logic [DIV_W-1:0] ub;
    logic             neg;
    logic             zero;
    side_t            side;
  } div_req_t;

  typedef struct packed {
    logic [DIV_W-1:0] q;
    logic             neg;
    logic             zero;
    side_t            side;
  } div_res_t;

endpackage

/* sv/escu_temp.sv */
// ----------------------------------------------------------------------------
// escu_temp : temperature stages
// four stages giving fine temperature derived terms and centi-degrees
// ----------------------------------------------------------------------------
module escu_temp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  escu_pkg::in_beat_t  in_beat,
  input  escu_pkg::calib_t    calib,
  output logic                out_vld,
  output escu_pkg::temp_res_t out_res
);

  logic [3:0]  vld_r;
  logic [15:0] t1;
  logic [31:0] t2, t3;
  logic [31:0] diff, dlt;

  logic [31:0] s1_aprod_r, s1_dd_r;
  logic [31:0] s2_a_r, s2_bprod_r;
  logic [31:0] s3_tf_r;
  escu_pkg::in_beat_t s1_beat_r, s2_beat_r, s3_beat_r;
  escu_pkg::temp_res_t s4_res_r;

  assign t1 = calib.temp[15:0];
  assign t2 = {{16{calib.temp[31]}}, calib.temp[31:16]};
  assign t3 = {{16{calib.temp[47]}}, calib.temp[47:32]};

  assign diff = {15'b0, in_beat.adc_temp[19:3]} - {15'b0, t1, 1'b0};
  assign dlt  = {16'b0, in_beat.adc_temp[19:4]} - {16'b0, t1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    // products
    s1_aprod_r <= diff * t2;
    s1_dd_r    <= dlt * dlt;
    s1_beat_r  <= in_beat;
    // scale
    s2_a_r     <= 32'($signed(s1_aprod_r) >>> 11);
    s2_bprod_r <= 32'($signed(s1_dd_r) >>> 12) * t3;
    s2_beat_r  <= s1_beat_r;
    // fine temperature
    s3_tf_r    <= s2_a_r + 32'($signed(s2_bprod_r) >>> 14);
    s3_beat_r  <= s2_beat_r;
    // centi-degrees and offsets for the other two formulas
    s4_res_r.tc <= 32'($signed(s3_tf_r + (s3_tf_r << 2) + escu_pkg::TEMP_ROUND) >>> 8);
    s4_res_r.v1 <= {s3_tf_r[31], s3_tf_r} - escu_pkg::TEMP_PRESS_OFS;
    s4_res_r.x  <= s3_tf_r - escu_pkg::TEMP_HUM_OFS;
    s4_res_r.adc_press <= s3_beat_r.adc_press;
    s4_res_r.adc_hum   <= s3_beat_r.adc_hum;
  end

  assign out_vld = vld_r[3];
  assign out_res = s4_res_r;

endmodule

/* sv/escu_front.sv */
// ----------------------------------------------------------------------------
// escu_front : pressure numerator/denominator and humidity stages
// seven stages; pressure ends as sign and magnitudes ready for the divider,
// humidity ends fully clamped
// ----------------------------------------------------------------------------
module escu_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  escu_pkg::temp_res_t in_res,
  input  escu_pkg::calib_t    calib,
  output logic                out_vld,
  output escu_pkg::div_req_t  out_req
);

  logic [6:0]  vld_r;
  logic [15:0] p1, p2, p3, p4, p5, p6;
  logic [31:0] h1, h2, h3, h4, h5, h6;

  // pressure path
  logic [63:0] f1_vv_r, f1_v1p5_r, f1_v1p2_r;
  logic [63:0] f2_v2a_r, f2_t3a_r, f2_v1p5_r, f2_v1p2_r;
  logic [63:0] f3_v2b_r, f3_v1b_r;
  logic [63:0] f4_v2_r, f4_m_r;
  logic [63:0] f5_n0_r, f5_m_r;
  logic [63:0] f6_num_r, f6_den_r;
  logic [19:0] f1_ap_r, f2_ap_r, f3_ap_r, f4_ap_r;
  // humidity path
  logic [31:0] f1_hapre_r, f1_xh6_r, f1_xh3_r;
  logic [31:0] f2_ha_r, f2_hb0_r;
  logic [31:0] f3_ha_r, f3_hb2m_r;
  logic [31:0] f4_xx_r, f5_xx_r, f5_ss_r, f6_xx_r, f6_sh_r;
  logic [31:0] f1_tc_r, f2_tc_r, f3_tc_r, f4_tc_r, f5_tc_r, f6_tc_r;
  logic [31:0] hb, y;
  escu_pkg::div_req_t f7_req_r;

  assign p1 = calib.press_a[15:0];
  assign p2 = calib.press_a[31:16];
  assign p3 = calib.press_a[47:32];
  assign p4 = calib.press_a[63:48];
  assign p5 = calib.press_b[15:0];
  assign p6 = calib.press_b[31:16];
  assign h1 = {24'b0, calib.hum[7:0]};
  assign h2 = {{16{calib.hum[23]}}, calib.hum[23:8]};
  assign h3 = {24'b0, calib.hum[31:24]};
  assign h4 = {{16{calib.hum[47]}}, calib.hum[47:32]};
  assign h5 = {{16{calib.hum[63]}}, calib.hum[63:48]};
  assign h6 = {{24{calib.hum_h6[7]}}, calib.hum_h6};

  assign hb = 32'($signed(f3_hb2m_r + escu_pkg::HUM_ROUND_B) >>> 14);
  assign y  = f6_xx_r - 32'($signed(f6_sh_r) >>> 4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[5:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    // f1
    f1_vv_r    <= 64'($signed(in_res.v1) * $signed(in_res.v1));
    f1_v1p5_r  <= 64'($signed(in_res.v1) * $signed(p5));
    f1_v1p2_r  <= 64'($signed(in_res.v1) * $signed(p2));
    f1_ap_r    <= in_res.adc_press;
    f1_hapre_r <= ({16'b0, in_res.adc_hum} << 14) - (h4 << 20) - h5 * in_res.x
                  + escu_pkg::HUM_ROUND;
    f1_xh6_r   <= in_res.x * h6;
    f1_xh3_r   <= in_res.x * h3;
    f1_tc_r    <= in_res.tc;
    // f2
    f2_v2a_r   <= 64'($signed(f1_vv_r) * $signed(p6));
    f2_t3a_r   <= 64'($signed(f1_vv_r) * $signed(p3));
    f2_v1p5_r  <= f1_v1p5_r;
    f2_v1p2_r  <= f1_v1p2_r;
    f2_ap_r    <= f1_ap_r;
    f2_ha_r    <= 32'($signed(f1_hapre_r) >>> 15);
    f2_hb0_r   <= 32'($signed(f1_xh6_r) >>> 10)
                  * (32'($signed(f1_xh3_r) >>> 11) + escu_pkg::HUM_HALF);
    f2_tc_r    <= f1_tc_r;
    // f3
    f3_v2b_r   <= f2_v2a_r + (f2_v1p5_r << 17);
    f3_v1b_r   <= 64'($signed(f2_t3a_r) >>> 8) + (f2_v1p2_r << 12);
    f3_ap_r    <= f2_ap_r;
    f3_ha_r    <= f2_ha_r;
    f3_hb2m_r  <= (32'($signed(f2_hb0_r) >>> 10) + escu_pkg::HUM_OFS) * h2;
    f3_tc_r    <= f2_tc_r;
    // f4
    f4_v2_r    <= f3_v2b_r + ({{48{p4[15]}}, p4} << 35);
    f4_m_r     <= (escu_pkg::PRESS_BIAS + f3_v1b_r) * {48'b0, p1};
    f4_ap_r    <= f3_ap_r;
    f4_xx_r    <= f3_ha_r * hb;
    f4_tc_r    <= f3_tc_r;
    // f5
    f5_n0_r    <= ((escu_pkg::PRESS_FULL - {44'b0, f4_ap_r}) << 31) - f4_v2_r;
    f5_m_r     <= f4_m_r;
    f5_xx_r    <= f4_xx_r;
    f5_ss_r    <= 32'($signed(f4_xx_r) >>> 15) * 32'($signed(f4_xx_r) >>> 15);
    f5_tc_r    <= f4_tc_r;
    // f6
    f6_num_r   <= f5_n0_r * escu_pkg::PRESS_SCALE;
    f6_den_r   <= 64'($signed(f5_m_r) >>> 33);
    f6_xx_r    <= f5_xx_r;
    f6_sh_r    <= 32'($signed(f5_ss_r) >>> 7) * h1;
    f6_tc_r    <= f5_tc_r;
    // f7: magnitudes for the divider, humidity clamp
    f7_req_r.ua   <= f6_num_r[63] ? 64'(0) - f6_num_r : f6_num_r;
    f7_req_r.ub   <= f6_den_r[63] ? 64'(0) - f6_den_r : f6_den_r;
    f7_req_r.neg  <= f6_num_r[63] ^ f6_den_r[63];
    f7_req_r.zero <= (f6_den_r == 64'd0);
    f7_req_r.side.tc <= f6_tc_r;
    if (y[31]) begin
      f7_req_r.side.hum <= '0;
    end else if (y > escu_pkg::HUM_MAX) begin
      f7_req_r.side.hum <= escu_pkg::HUM_MAX[28:12];
    end else begin
      f7_req_r.side.hum <= y[28:12];
    end
  end

  assign out_vld = vld_r[6];
  assign out_req = f7_req_r;

endmodule

/* sv/escu_div.sv */
// ----------------------------------------------------------------------------
// escu_div : pipelined unsigned divider
// restoring division, one quotient bit per stage, side data carried along
// ----------------------------------------------------------------------------
module escu_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  escu_pkg::div_req_t in_req,
  output logic               out_vld,
  output escu_pkg::div_res_t out_res
);

  localparam int W = escu_pkg::DIV_W;

  logic [W-1:0]    vld_r;
  logic [W-1:0]    rem_r  [W];
  logic [W-1:0]    quo_r  [W];
  logic [W-1:0]    den_r  [W];
  logic            neg_r  [W];
  logic            zero_r [W];
  escu_pkg::side_t side_r [W];

  for (genvar i = 0; i < W; i++) begin : g_stage
    logic [W-1:0]    rem_in, quo_in, den_in;
    logic            neg_in, zero_in, vld_in;
    escu_pkg::side_t side_in;
    logic [W:0]      trial, diff;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign quo_in  = in_req.ua;
      assign den_in  = in_req.ub;
      assign neg_in  = in_req.neg;
      assign zero_in = in_req.zero;
      assign side_in = in_req.side;
      assign vld_in  = in_vld;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign quo_in  = quo_r[i-1];
      assign den_in  = den_r[i-1];
      assign neg_in  = neg_r[i-1];
      assign zero_in = zero_r[i-1];
      assign side_in = side_r[i-1];
      assign vld_in  = vld_r[i-1];
    end

    assign trial = {rem_in, quo_in[W-1]};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      // borrow out means the trial remainder is below the divisor
      if (!diff[W]) begin
        rem_r[i] <= diff[W-1:0];
        quo_r[i] <= {quo_in[W-2:0], 1'b1};
      end else begin
        rem_r[i] <= trial[W-1:0];
        quo_r[i] <= {quo_in[W-2:0], 1'b0};
      end
      den_r[i]  <= den_in;
      neg_r[i]  <= neg_in;
      zero_r[i] <= zero_in;
      side_r[i] <= side_in;
    end
  end

  assign out_vld      = vld_r[W-1];
  assign out_res.q    = quo_r[W-1];
  assign out_res.neg  = neg_r[W-1];
  assign out_res.zero = zero_r[W-1];
  assign out_res.side = side_r[W-1];

endmodule

/* sv/escu_post.sv */
// ----------------------------------------------------------------------------
// escu_post : pressure tail stages
// signed quotient, square and trim terms, final Q24.8 pressure and output beat
// ----------------------------------------------------------------------------
module escu_post (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  escu_pkg::div_res_t  in_res,
  input  escu_pkg::calib_t    calib,
  output logic                out_vld,
  output escu_pkg::out_beat_t out_beat
);

  logic [4:0]  vld_r;
  logic [15:0] p7, p8, p9;
  logic [63:0] qs, sum;

  logic [63:0] q1_p_r, q2_p_r, q3_p_r, q4_p_r;
  logic [63:0] q2_ll_r, q2_p8p_r, q3_qq_r, q3_p8p_r, q4_p8p_r, q4_v1c_r;
  logic [31:0] q2_lh_r;
  logic        q1_zero_r, q2_zero_r, q3_zero_r, q4_zero_r;
  escu_pkg::side_t q1_side_r, q2_side_r, q3_side_r, q4_side_r;
  escu_pkg::out_beat_t q5_beat_r;

  assign p7 = calib.press_b[47:32];
  assign p8 = calib.press_b[63:48];
  assign p9 = calib.press_c;

  assign qs  = 64'($signed(q1_p_r) >>> 13);
  assign sum = q4_p_r + 64'($signed(q4_v1c_r) >>> 25) + 64'($signed(q4_p8p_r) >>> 19);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    // q1: apply sign
    q1_p_r    <= in_res.neg ? 64'(0) - in_res.q : in_res.q;
    q1_zero_r <= in_res.zero;
    q1_side_r <= in_res.side;
    // q2: partial products of the square, P8 term
    q2_ll_r   <= {32'b0, qs[31:0]} * {32'b0, qs[31:0]};
    q2_lh_r   <= qs[31:0] * qs[63:32];
    q2_p8p_r  <= 64'($signed(q1_p_r) * $signed(p8));
    q2_p_r    <= q1_p_r;
    q2_zero_r <= q1_zero_r;
    q2_side_r <= q1_side_r;
    // q3: low 64 bits of the square
    q3_qq_r   <= q2_ll_r + {q2_lh_r[30:0], 33'b0};
    q3_p8p_r  <= q2_p8p_r;
    q3_p_r    <= q2_p_r;
    q3_zero_r <= q2_zero_r;
    q3_side_r <= q2_side_r;
    // q4: P9 term
    q4_v1c_r  <= 64'($signed(q3_qq_r) * $signed(p9));
    q4_p8p_r  <= q3_p8p_r;
    q4_p_r    <= q3_p_r;
    q4_zero_r <= q3_zero_r;
    q4_side_r <= q3_side_r;
    // q5: output beat
    q5_beat_r.temp_centi_deg <= q4_side_r.tc;
    q5_beat_r.hum_q22_10     <= q4_side_r.hum;
    if (q4_zero_r) begin
      q5_beat_r.press_q24_8 <= '0;
    end else begin
      q5_beat_r.press_q24_8 <= 32'($signed(sum) >>> 8) + ({{16{p7[15]}}, p7} << 4);
    end
  end

  assign out_vld  = vld_r[4];
  assign out_beat = q5_beat_r;

endmodule

/* sv/env_sensor_compensation_unit.sv */
// ----------------------------------------------------------------------------
// env_sensor_compensation_unit : environmental sensor compensation pipeline
// integer temperature, pressure and humidity compensation of one raw sample
// per beat, calibration coefficients held in a small register bank
//
//   channel   ports                                 handshake
//   input     start, busy, in_beat                  start & !busy
//   result    out_valid, out_beat                   out_valid, one cycle
//   config    cfg_valid, cfg_ready, cfg_index/data  cfg_valid & cfg_ready
//
// one sample may start every cycle; a result appears after the stages below
// stages: 4 temperature + 7 front + 64 divider + 5 tail; the
// divider, one quotient bit per stage, sets the depth
// busy never rises, the result channel has no back-pressure
// synchronous active-low reset clears the valid pipeline and the calibration
// ----------------------------------------------------------------------------
module env_sensor_compensation_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  escu_pkg::in_beat_t                  in_beat,
  output logic                                out_valid,
  output escu_pkg::out_beat_t                 out_beat,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [escu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [escu_pkg::CFG_DATA_W-1:0]     cfg_data
);

  escu_pkg::calib_t    calib_r;
  escu_pkg::temp_res_t temp_res;
  escu_pkg::div_req_t  div_req;
  escu_pkg::div_res_t  div_res;
  logic                in_acc, temp_vld, front_vld, div_vld;

  // fully pipelined, never stalls
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_acc    = start & ~busy;

  // calibration bank, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        escu_pkg::REG_TEMP_CALIB:    calib_r.temp    <= cfg_data[47:0];
        escu_pkg::REG_PRESS_CALIB_A: calib_r.press_a <= cfg_data;
        escu_pkg::REG_PRESS_CALIB_B: calib_r.press_b <= cfg_data;
        escu_pkg::REG_PRESS_CALIB_C: calib_r.press_c <= cfg_data[15:0];
        escu_pkg::REG_HUM_CALIB:     calib_r.hum     <= cfg_data;
        escu_pkg::REG_HUM_CALIB_H6:  calib_r.hum_h6  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // fine temperature and centi-degrees
  escu_temp u_temp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_acc),
    .in_beat (in_beat),
    .calib   (calib_r),
    .out_vld (temp_vld),
    .out_res (temp_res)
  );

  // pressure numerator and divisor, humidity in parallel
  escu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (temp_vld),
    .in_res  (temp_res),
    .calib   (calib_r),
    .out_vld (front_vld),
    .out_req (div_req)
  );

  // 64-bit magnitude division
  escu_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (front_vld),
    .in_req  (div_req),
    .out_vld (div_vld),
    .out_res (div_res)
  );

  // pressure trim and output register
  escu_post u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (div_vld),
    .in_res   (div_res),
    .calib    (calib_r),
    .out_vld  (out_valid),
    .out_beat (out_beat)
  );

`ifndef SYNTHESIS
  // every accepted beat leaves after the temperature, front, divider and tail stages
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##80 out_valid)
    else $error("result missing after accepted beat");

  // humidity stays inside its clamp
  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_beat.hum_q22_10 <= escu_pkg::HUM_OUT_MAX))
    else $error("humidity out of range");

  // reset empties the pipeline
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe after reset");
`endif

endmodule
